// ----- sv/rmb_pkg.sv -----
// rmb_pkg: fixed-point formats, pipeline stage map and constant tables
// for the rotation matrix builder. Depends on nothing.
package rmb_pkg;

   localparam int QW = 34;
   localparam int PW = 2 * QW;

   typedef logic signed [QW-1:0] q_type;

   localparam q_type Q_ONE       = 34'sd1073741824;
   localparam q_type Q_PI        = 34'sd3373259426;
   localparam q_type Q_TWO_PI    = 34'sd6746518852;
   localparam q_type Q_HALF_PI   = 34'sd1686629713;
   localparam q_type CORDIC_GAIN = 34'sd652032874;

   localparam int CORDIC_STEPS = 30;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 31;

   // axis path stage map
   localparam int IDX_SHIFT0 = 1;
   localparam int SHIFT_STEPS = 5;
   localparam int IDX_SQUARE = IDX_SHIFT0 + SHIFT_STEPS;
   localparam int IDX_SUM    = IDX_SQUARE + 1;
   localparam int IDX_SQRT0  = IDX_SUM + 1;
   localparam int IDX_DIV0   = IDX_SQRT0 + SQRT_STEPS;
   localparam int AXIS_DEPTH = IDX_DIV0 + DIV_STEPS;

   // angle path stage map, aligned to end with the axis path
   localparam int CORDIC_DEPTH = 2 + CORDIC_STEPS + 1;
   localparam int IDX_REDUCE   = AXIS_DEPTH - CORDIC_DEPTH;
   localparam int IDX_FOLD     = IDX_REDUCE + 1;
   localparam int IDX_ITER0    = IDX_FOLD + 1;
   localparam int IDX_SIGN     = IDX_ITER0 + CORDIC_STEPS;

   localparam int MUL_STAGES = 4;
   localparam int PIPE_DEPTH = AXIS_DEPTH + MUL_STAGES;

   localparam q_type ATAN_TAB [CORDIC_STEPS] = '{
      34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
      34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
      34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
      34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
      34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
      34'sh0000001F, 34'sh0000000F, 34'sh00000008, 34'sh00000004, 34'sh00000002
   };

   function automatic q_type qmul(input q_type a, input q_type b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b) + PW'(64'sd536870912);
      return q_type'(p >>> 30);
   endfunction

endpackage

// ----- sv/rotation_matrix_builder_unit.sv -----
// rotation_matrix_builder_unit: pipelined 3x3 rotation matrix builder.
// Depends on rmb_pkg.
//
// Usage:
//   Request channel req_*: op selects Euler xyz angles (0) or axis/angle (1).
//   A request is taken at a rising edge with req_valid high and req_stall low.
//   Response channel rsp_*: nine Q2.14 elements m00..m22 in row-major order
//   and zero_axis, taken at an edge with rsp_valid high and rsp_stall low.
//   One request per cycle is sustained unless rsp_stall holds a response.
//   Depth is set by the axis path: a 32-step square root
//   followed by a 31-step divider, one step per stage; the three 30-step
//   CORDIC lanes run alongside, then four multiply/sum stages and the output
//   rounding register.
//   Reset (synchronous, active high) clears all valid bits; no response is
//   pending afterwards. While a response is held with rsp_stall high the whole
//   pipeline freezes and req_stall is raised in the same cycle.
module rotation_matrix_builder_unit #(
   parameter int ANGLE_BITS   = 16,
   parameter int ELEMENT_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic signed [ANGLE_BITS-1:0]   req_angle_x,
   input  logic signed [ANGLE_BITS-1:0]   req_angle_y,
   input  logic signed [ANGLE_BITS-1:0]   req_angle_z,
   input  logic signed [ANGLE_BITS-1:0]   req_spin_angle,
   input  logic signed [ELEMENT_BITS-1:0] req_axis_x,
   input  logic signed [ELEMENT_BITS-1:0] req_axis_y,
   input  logic signed [ELEMENT_BITS-1:0] req_axis_z,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [ELEMENT_BITS-1:0] rsp_m00,
   output logic signed [ELEMENT_BITS-1:0] rsp_m01,
   output logic signed [ELEMENT_BITS-1:0] rsp_m02,
   output logic signed [ELEMENT_BITS-1:0] rsp_m10,
   output logic signed [ELEMENT_BITS-1:0] rsp_m11,
   output logic signed [ELEMENT_BITS-1:0] rsp_m12,
   output logic signed [ELEMENT_BITS-1:0] rsp_m20,
   output logic signed [ELEMENT_BITS-1:0] rsp_m21,
   output logic signed [ELEMENT_BITS-1:0] rsp_m22,
   output logic                           rsp_zero_axis
);

   localparam int AXD = rmb_pkg::AXIS_DEPTH;
   localparam int PD  = rmb_pkg::PIPE_DEPTH;
   localparam int LST = AXD - 1;
   localparam int ANG_SHIFT = 34 - ANGLE_BITS;
   localparam int OUT_SHIFT = 32 - ELEMENT_BITS;

   localparam logic signed [35:0] W_TWO_PI  = 36'(rmb_pkg::Q_TWO_PI);
   localparam logic signed [35:0] W_FOUR_PI = W_TWO_PI <<< 1;
   localparam logic signed [35:0] OUT_RND   = 36'((64'sd1 <<< OUT_SHIFT) >>> 1);
   localparam logic signed [35:0] OUT_LIM   = 36'sd1 <<< (ELEMENT_BITS - 2);

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] ang;
      rmb_pkg::q_type               r;
      logic                         neg;
      rmb_pkg::q_type               x;
      rmb_pkg::q_type               y;
   } lane_type;

   typedef struct packed {
      logic             op;
      logic             zero;
      logic [2:0]       sgn;
      logic [2:0][31:0] mag;
      logic [31:0]      mx;
      logic [2:0][63:0] sq;
      logic [63:0]      n;
      logic [63:0]      res;
      logic [31:0]      len;
      logic [2:0][63:0] rem;
      logic [2:0][30:0] quo;
   } axis_type;

   typedef struct packed {
      logic op;
      logic zero;
   } ctl_type;

   logic en;
   logic [PD-1:0] vld_ff, vld_in;
   logic rsp_valid_ff;

   lane_type ang_ff [AXD][3];
   lane_type ang_in [AXD][3];
   axis_type ax_ff [AXD];
   axis_type ax_in [AXD];

   ctl_type ctl_ff [rmb_pkg::MUL_STAGES];
   ctl_type ctl_in [rmb_pkg::MUL_STAGES];

   rmb_pkg::q_type m0_s_ff [3], m0_s_in [3];
   rmb_pkg::q_type m0_c_ff [3], m0_c_in [3];
   rmb_pkg::q_type m0_u_ff [3], m0_u_in [3];
   rmb_pkg::q_type m0_t_ff, m0_t_in;

   rmb_pkg::q_type p1_ff [10], p1_in [10];
   rmb_pkg::q_type m1_s_ff [3], m1_c_ff [3], m1_u_ff [3];
   rmb_pkg::q_type a1 [10], b1 [10];

   rmb_pkg::q_type p2_ff [6], p2_in [6];
   rmb_pkg::q_type p1d_ff [10];
   rmb_pkg::q_type m2_sy_ff, m2_c_ff;
   rmb_pkg::q_type a2 [6], b2 [6];

   rmb_pkg::q_type e_ff [9], e_in [9];

   logic signed [ELEMENT_BITS-1:0] out_ff [9], out_in [9];
   logic zero_out_ff;
   logic signed [35:0] ov [9];

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign vld_in    = {vld_ff[PD-2:0], req_valid};

   // axis path: magnitude, normalize, sum of squares, square root, divide
   for (genvar j = 0; j < AXD; j++) begin : g_ax
      if (j == 0) begin : g_cap
         logic signed [ELEMENT_BITS:0] ext [3];
         logic [31:0] mx01;
         always_comb begin
            ext[0] = (ELEMENT_BITS + 1)'(req_axis_x);
            ext[1] = (ELEMENT_BITS + 1)'(req_axis_y);
            ext[2] = (ELEMENT_BITS + 1)'(req_axis_z);
            ax_in[0] = '0;
            ax_in[0].op = req_op;
            for (int l = 0; l < 3; l++) begin
               ax_in[0].sgn[l] = ext[l][ELEMENT_BITS];
               ax_in[0].mag[l] = 32'($unsigned(ext[l][ELEMENT_BITS] ? -ext[l] : ext[l]));
            end
            mx01 = (ax_in[0].mag[0] > ax_in[0].mag[1]) ? ax_in[0].mag[0] : ax_in[0].mag[1];
            ax_in[0].mx = (mx01 > ax_in[0].mag[2]) ? mx01 : ax_in[0].mag[2];
            ax_in[0].zero = req_op && (ax_in[0].mx == 32'd0);
         end
      end else if (j < rmb_pkg::IDX_SQUARE) begin : g_shift
         localparam int S = 16 >> (j - rmb_pkg::IDX_SHIFT0);
         always_comb begin
            ax_in[j] = ax_ff[j-1];
            if (ax_ff[j-1].mx < (32'd1 << (31 - S))) begin
               ax_in[j].mx = ax_ff[j-1].mx << S;
               for (int l = 0; l < 3; l++) begin
                  ax_in[j].mag[l] = ax_ff[j-1].mag[l] << S;
               end
            end
         end
      end else if (j == rmb_pkg::IDX_SQUARE) begin : g_sq
         always_comb begin
            ax_in[j] = ax_ff[j-1];
            for (int l = 0; l < 3; l++) begin
               ax_in[j].sq[l] = 64'(ax_ff[j-1].mag[l]) * 64'(ax_ff[j-1].mag[l]);
            end
         end
      end else if (j == rmb_pkg::IDX_SUM) begin : g_sum
         always_comb begin
            ax_in[j] = ax_ff[j-1];
            ax_in[j].n = ax_ff[j-1].sq[0] + ax_ff[j-1].sq[1] + ax_ff[j-1].sq[2];
            ax_in[j].res = '0;
         end
      end else if (j < rmb_pkg::IDX_DIV0) begin : g_sqrt
         localparam int K = j - rmb_pkg::IDX_SQRT0;
         localparam logic [63:0] BIT = 64'd1 << (62 - 2 * K);
         logic [63:0] trial;
         always_comb begin
            ax_in[j] = ax_ff[j-1];
            trial = ax_ff[j-1].res + BIT;
            if (ax_ff[j-1].n >= trial) begin
               ax_in[j].n   = ax_ff[j-1].n - trial;
               ax_in[j].res = (ax_ff[j-1].res >> 1) + BIT;
            end else begin
               ax_in[j].res = ax_ff[j-1].res >> 1;
            end
         end
      end else begin : g_div
         localparam int I = rmb_pkg::DIV_STEPS - 1 - (j - rmb_pkg::IDX_DIV0);
         axis_type cur;
         logic [63:0] dvs;
         always_comb begin
            cur = ax_ff[j-1];
            if (j == rmb_pkg::IDX_DIV0) begin
               cur.len = ax_ff[j-1].res[31:0];
               cur.quo = '0;
               for (int l = 0; l < 3; l++) begin
                  cur.rem[l] = {2'b00, cur.mag[l], 30'd0} + 64'(cur.len >> 1);
               end
            end
            dvs = 64'(cur.len) << I;
            for (int l = 0; l < 3; l++) begin
               if (cur.rem[l] >= dvs) begin
                  cur.rem[l]    = cur.rem[l] - dvs;
                  cur.quo[l][I] = 1'b1;
               end
            end
            ax_in[j] = cur;
         end
      end
   end

   // angle path: delay, reduce mod two pi, fold, CORDIC, sign
   for (genvar j = 0; j < AXD; j++) begin : g_ang
      if (j == 0) begin : g_cap
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               ang_in[0][l] = '0;
            end
            ang_in[0][0].ang = req_op ? req_spin_angle : req_angle_x;
            ang_in[0][1].ang = req_angle_y;
            ang_in[0][2].ang = req_angle_z;
         end
      end else if (j < rmb_pkg::IDX_REDUCE) begin : g_dly
         always_comb begin
            ang_in[j] = ang_ff[j-1];
         end
      end else if (j == rmb_pkg::IDX_REDUCE) begin : g_red
         logic signed [35:0] v [3];
         logic signed [35:0] rr [3];
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               ang_in[j][l] = ang_ff[j-1][l];
               v[l] = 36'(ang_ff[j-1][l].ang) <<< ANG_SHIFT;
               if (v[l] >= W_TWO_PI) begin
                  rr[l] = v[l] - W_TWO_PI;
               end else if (v[l] >= 36'sd0) begin
                  rr[l] = v[l];
               end else if (v[l] + W_TWO_PI >= 36'sd0) begin
                  rr[l] = v[l] + W_TWO_PI;
               end else begin
                  rr[l] = v[l] + W_FOUR_PI;
               end
               ang_in[j][l].r = rmb_pkg::q_type'(rr[l]);
            end
         end
      end else if (j == rmb_pkg::IDX_FOLD) begin : g_fold
         rmb_pkg::q_type rf [3];
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               ang_in[j][l] = ang_ff[j-1][l];
               rf[l] = ang_ff[j-1][l].r;
               if (rf[l] >= rmb_pkg::Q_PI) begin
                  rf[l] = rf[l] - rmb_pkg::Q_TWO_PI;
               end
               ang_in[j][l].neg = 1'b0;
               if (rf[l] > rmb_pkg::Q_HALF_PI) begin
                  rf[l] = rf[l] - rmb_pkg::Q_PI;
                  ang_in[j][l].neg = 1'b1;
               end else if (rf[l] < -rmb_pkg::Q_HALF_PI) begin
                  rf[l] = rf[l] + rmb_pkg::Q_PI;
                  ang_in[j][l].neg = 1'b1;
               end
               ang_in[j][l].r = rf[l];
               ang_in[j][l].x = rmb_pkg::CORDIC_GAIN;
               ang_in[j][l].y = '0;
            end
         end
      end else if (j < rmb_pkg::IDX_SIGN) begin : g_iter
         localparam int I = j - rmb_pkg::IDX_ITER0;
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               ang_in[j][l] = ang_ff[j-1][l];
               if (ang_ff[j-1][l].r >= 0) begin
                  ang_in[j][l].x = ang_ff[j-1][l].x - (ang_ff[j-1][l].y >>> I);
                  ang_in[j][l].y = ang_ff[j-1][l].y + (ang_ff[j-1][l].x >>> I);
                  ang_in[j][l].r = ang_ff[j-1][l].r - rmb_pkg::ATAN_TAB[I];
               end else begin
                  ang_in[j][l].x = ang_ff[j-1][l].x + (ang_ff[j-1][l].y >>> I);
                  ang_in[j][l].y = ang_ff[j-1][l].y - (ang_ff[j-1][l].x >>> I);
                  ang_in[j][l].r = ang_ff[j-1][l].r + rmb_pkg::ATAN_TAB[I];
               end
            end
         end
      end else begin : g_sign
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               ang_in[j][l] = ang_ff[j-1][l];
               if (ang_ff[j-1][l].neg) begin
                  ang_in[j][l].x = -ang_ff[j-1][l].x;
                  ang_in[j][l].y = -ang_ff[j-1][l].y;
               end
            end
         end
      end
   end

   // M0: signed unit axis, t = 1 - cos
   always_comb begin
      ctl_in[0] = '{op: ax_ff[LST].op, zero: ax_ff[LST].zero};
      for (int l = 0; l < 3; l++) begin
         m0_s_in[l] = ang_ff[LST][l].y;
         m0_c_in[l] = ang_ff[LST][l].x;
         m0_u_in[l] = ax_ff[LST].sgn[l] ? -rmb_pkg::q_type'(ax_ff[LST].quo[l])
                                        : rmb_pkg::q_type'(ax_ff[LST].quo[l]);
      end
      m0_t_in = rmb_pkg::Q_ONE - ang_ff[LST][0].x;
   end

   // M1: first products
   always_comb begin
      ctl_in[1] = ctl_ff[0];
      if (ctl_ff[0].op) begin
         a1[0] = m0_t_ff;    b1[0] = m0_u_ff[0];
         a1[1] = m0_t_ff;    b1[1] = m0_u_ff[1];
         a1[2] = m0_t_ff;    b1[2] = m0_u_ff[2];
         a1[3] = m0_s_ff[0]; b1[3] = m0_u_ff[0];
         a1[4] = m0_s_ff[0]; b1[4] = m0_u_ff[1];
         a1[5] = m0_s_ff[0]; b1[5] = m0_u_ff[2];
         for (int k = 6; k < 10; k++) begin
            a1[k] = '0;
            b1[k] = '0;
         end
      end else begin
         a1[0] = m0_s_ff[0]; b1[0] = m0_s_ff[1];
         a1[1] = m0_c_ff[0]; b1[1] = m0_s_ff[1];
         a1[2] = m0_c_ff[1]; b1[2] = m0_c_ff[2];
         a1[3] = m0_c_ff[1]; b1[3] = m0_s_ff[2];
         a1[4] = m0_c_ff[0]; b1[4] = m0_s_ff[2];
         a1[5] = m0_s_ff[0]; b1[5] = m0_c_ff[1];
         a1[6] = m0_s_ff[0]; b1[6] = m0_s_ff[2];
         a1[7] = m0_s_ff[0]; b1[7] = m0_c_ff[2];
         a1[8] = m0_c_ff[0]; b1[8] = m0_c_ff[2];
         a1[9] = m0_c_ff[0]; b1[9] = m0_c_ff[1];
      end
      for (int k = 0; k < 10; k++) begin
         p1_in[k] = rmb_pkg::qmul(a1[k], b1[k]);
      end
   end

   // M2: second products
   always_comb begin
      ctl_in[2] = ctl_ff[1];
      if (ctl_ff[1].op) begin
         a2[0] = p1_ff[0]; b2[0] = m1_u_ff[0];
         a2[1] = p1_ff[0]; b2[1] = m1_u_ff[1];
         a2[2] = p1_ff[0]; b2[2] = m1_u_ff[2];
         a2[3] = p1_ff[1]; b2[3] = m1_u_ff[2];
         a2[4] = p1_ff[1]; b2[4] = m1_u_ff[1];
         a2[5] = p1_ff[2]; b2[5] = m1_u_ff[2];
      end else begin
         a2[0] = p1_ff[0]; b2[0] = m1_c_ff[2];
         a2[1] = p1_ff[0]; b2[1] = m1_s_ff[2];
         a2[2] = p1_ff[1]; b2[2] = m1_c_ff[2];
         a2[3] = p1_ff[1]; b2[3] = m1_s_ff[2];
         a2[4] = '0;       b2[4] = '0;
         a2[5] = '0;       b2[5] = '0;
      end
      for (int k = 0; k < 6; k++) begin
         p2_in[k] = rmb_pkg::qmul(a2[k], b2[k]);
      end
   end

   // M3: element sums, or the identity for a zero axis
   always_comb begin
      ctl_in[3] = ctl_ff[2];
      if (ctl_ff[2].zero) begin
         for (int k = 0; k < 9; k++) begin
            e_in[k] = (k % 4 == 0) ? rmb_pkg::Q_ONE : '0;
         end
      end else if (ctl_ff[2].op) begin
         e_in[0] = p2_ff[0] + m2_c_ff;
         e_in[1] = p2_ff[1] - p1d_ff[5];
         e_in[2] = p2_ff[2] + p1d_ff[4];
         e_in[3] = p2_ff[1] + p1d_ff[5];
         e_in[4] = p2_ff[4] + m2_c_ff;
         e_in[5] = p2_ff[3] - p1d_ff[3];
         e_in[6] = p2_ff[2] - p1d_ff[4];
         e_in[7] = p2_ff[3] + p1d_ff[3];
         e_in[8] = p2_ff[5] + m2_c_ff;
      end else begin
         e_in[0] = p1d_ff[2];
         e_in[1] = -p1d_ff[3];
         e_in[2] = m2_sy_ff;
         e_in[3] = p2_ff[0] + p1d_ff[4];
         e_in[4] = p1d_ff[8] - p2_ff[1];
         e_in[5] = -p1d_ff[5];
         e_in[6] = p1d_ff[6] - p2_ff[2];
         e_in[7] = p2_ff[3] + p1d_ff[7];
         e_in[8] = p1d_ff[9];
      end
   end

   // output rounding and saturation
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         ov[k] = (36'(e_ff[k]) + OUT_RND) >>> OUT_SHIFT;
         if (ov[k] > OUT_LIM) begin
            ov[k] = OUT_LIM;
         end else if (ov[k] < -OUT_LIM) begin
            ov[k] = -OUT_LIM;
         end
         out_in[k] = ov[k][ELEMENT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < rmb_pkg::MUL_STAGES; k++) begin
            ctl_ff[k] <= '0;
         end
      end else if (en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[PD-1];
         ctl_ff       <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff       <= ax_in;
         ang_ff      <= ang_in;
         m0_s_ff     <= m0_s_in;
         m0_c_ff     <= m0_c_in;
         m0_u_ff     <= m0_u_in;
         m0_t_ff     <= m0_t_in;
         p1_ff       <= p1_in;
         m1_s_ff     <= m0_s_ff;
         m1_c_ff     <= m0_c_ff;
         m1_u_ff     <= m0_u_ff;
         p2_ff       <= p2_in;
         p1d_ff      <= p1_ff;
         m2_sy_ff    <= m1_s_ff[1];
         m2_c_ff     <= m1_c_ff[0];
         e_ff        <= e_in;
         out_ff      <= out_in;
         zero_out_ff <= ctl_ff[3].zero;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_m00       = out_ff[0];
   assign rsp_m01       = out_ff[1];
   assign rsp_m02       = out_ff[2];
   assign rsp_m10       = out_ff[3];
   assign rsp_m11       = out_ff[4];
   assign rsp_m12       = out_ff[5];
   assign rsp_m20       = out_ff[6];
   assign rsp_m21       = out_ff[7];
   assign rsp_m22       = out_ff[8];
   assign rsp_zero_axis = zero_out_ff;

endmodule

// ----- sv/rmb_checker.sv -----
// rmb_checker: port-level assertions for rotation_matrix_builder_unit,
// attached by the bind below. Depends on nothing.
module rmb_checker #(
   parameter int ELEMENT_BITS = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [ELEMENT_BITS-1:0] rsp_m00,
   input logic signed [ELEMENT_BITS-1:0] rsp_m01,
   input logic signed [ELEMENT_BITS-1:0] rsp_m02,
   input logic signed [ELEMENT_BITS-1:0] rsp_m10,
   input logic signed [ELEMENT_BITS-1:0] rsp_m11,
   input logic signed [ELEMENT_BITS-1:0] rsp_m12,
   input logic signed [ELEMENT_BITS-1:0] rsp_m20,
   input logic signed [ELEMENT_BITS-1:0] rsp_m21,
   input logic signed [ELEMENT_BITS-1:0] rsp_m22,
   input logic                           rsp_zero_axis
);

   localparam logic signed [ELEMENT_BITS-1:0] ONE = ELEMENT_BITS'(1 << (ELEMENT_BITS - 2));

   logic signed [ELEMENT_BITS-1:0] el [9];
   logic in_range;
   logic ident;

   always_comb begin
      el = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12, rsp_m20, rsp_m21, rsp_m22};
      in_range = 1'b1;
      ident = 1'b1;
      for (int k = 0; k < 9; k++) begin
         if (el[k] > ONE || el[k] < -ONE) begin
            in_range = 1'b0;
         end
         if (el[k] != ((k % 4 == 0) ? ONE : '0)) begin
            ident = 1'b0;
         end
      end
   end

   a_stall_only_on_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while response side free");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_m00) && $stable(rsp_m12)
                                   && $stable(rsp_m22) && $stable(rsp_zero_axis)))
      else $error("stalled response changed");

   a_zero_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_axis) |-> ident)
      else $error("zero axis response is not identity");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_range)
      else $error("matrix element outside unit range");

endmodule

bind rotation_matrix_builder_unit rmb_checker #(.ELEMENT_BITS(ELEMENT_BITS)) u_rmb_checker (.*);

// ----- bench/tb_rotation_matrix_builder_unit.sv -----
// Testbench for rotation_matrix_builder_unit: drives Euler and axis/angle requests,
// predicts each rotation matrix in integer fixed point and checks every response.
// Depends on rmb_pkg and the block's RTL.
module tb_rotation_matrix_builder_unit;

   localparam int AB = 16;
   localparam int EB = 16;
   localparam longint TWO_PI = 64'sd6746518852;
   localparam longint PI_Q   = 64'sd3373259426;
   localparam longint HALF_PI = 64'sd1686629713;
   localparam longint ONE_Q  = 64'sd1073741824;
   localparam logic OP_EULER = 1'b0;
   localparam logic OP_AXIS  = 1'b1;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [EB-1:0] m [9];
      logic                 zero_axis;
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic signed [AB-1:0] req_angle_x = '0, req_angle_y = '0, req_angle_z = '0;
   logic signed [AB-1:0] req_spin_angle = '0;
   logic signed [EB-1:0] req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [EB-1:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [EB-1:0] rsp_m20, rsp_m21, rsp_m22;
   logic rsp_zero_axis;

   matrix_type expected_matrices[$];
   int     failures = 0;
   longint cycles = 0;
   bit     sending_done = 0;
   int     rsp_wait = 0;

   rotation_matrix_builder_unit #(.ANGLE_BITS(AB), .ELEMENT_BITS(EB)) u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   longint atan_q [30] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
      'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};

   function automatic logic rnd_op();
      return 1'($urandom);
   endfunction

   function automatic logic signed [AB-1:0] rnd_angle();
      return AB'($urandom);
   endfunction

   function automatic logic signed [EB-1:0] rnd_axis();
      return EB'($urandom);
   endfunction

   function automatic logic signed [EB-1:0] small_axis();
      return EB'(int'($urandom_range(0, 3)) - 2);
   endfunction

   function automatic longint fmul(longint a, longint b);
      return (a * b + 64'sd536870912) >>> 30;
   endfunction

   task automatic sine_cosine(input logic signed [AB-1:0] ang, output longint s,
                              output longint c);
      longint r, x, y, nx;
      bit     flip;
      r = (longint'(ang) <<< (34 - AB)) % TWO_PI;
      flip = 0;
      x = 64'sd652032874;
      y = 0;
      if (r < 0) r += TWO_PI;
      if (r >= PI_Q) r -= TWO_PI;
      if (r > HALF_PI) begin
         r -= PI_Q;
         flip = 1;
      end else if (r < -HALF_PI) begin
         r += PI_Q;
         flip = 1;
      end
      for (int i = 0; i < 30; i++) begin
         if (r >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            r -= atan_q[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            r += atan_q[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [EB-1:0] round_element(longint v);
      longint lim;
      lim = 64'sd1 << (EB - 2);
      v = (v + (64'sd1 << (30 - (EB - 2) - 1))) >>> (30 - (EB - 2));
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v[EB-1:0];
   endfunction

   task automatic build_matrix(input logic op, input logic signed [AB-1:0] ax, ay, az,
                               spin, input logic signed [EB-1:0] vx, vy, vz,
                               output matrix_type res);
      longint m[9];
      longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
      longint a[3], u[3], s, c, t, tx, ty, tz, txy, txz, tyz, q;
      longint unsigned mag[3], mx, sum, len;
      res.zero_axis = 1'b0;
      if (op == OP_EULER) begin
         sine_cosine(ax, sx, cx);
         sine_cosine(ay, sy, cy);
         sine_cosine(az, sz, cz);
         sxsy = fmul(sx, sy);
         cxsy = fmul(cx, sy);
         m[0] = fmul(cy, cz);
         m[1] = -fmul(cy, sz);
         m[2] = sy;
         m[3] = fmul(sxsy, cz) + fmul(cx, sz);
         m[4] = -fmul(sxsy, sz) + fmul(cx, cz);
         m[5] = -fmul(sx, cy);
         m[6] = -fmul(cxsy, cz) + fmul(sx, sz);
         m[7] = fmul(cxsy, sz) + fmul(sx, cz);
         m[8] = fmul(cx, cy);
      end else begin
         a[0] = longint'(vx);
         a[1] = longint'(vy);
         a[2] = longint'(vz);
         mx = 0;
         for (int i = 0; i < 3; i++) begin
            mag[i] = a[i] < 0 ? -a[i] : a[i];
            if (mag[i] > mx) mx = mag[i];
         end
         if (mx == 0) begin
            for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? ONE_Q : 64'sd0;
            res.zero_axis = 1'b1;
         end else begin
            while (mx < (64'd1 << 30)) begin
               mx <<= 1;
               for (int i = 0; i < 3; i++) mag[i] <<= 1;
            end
            sum = 0;
            for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
            len = floor_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
               q = ((mag[i] << 30) + len / 2) / len;
               u[i] = a[i] < 0 ? -q : q;
            end
            sine_cosine(spin, s, c);
            t = ONE_Q - c;
            tx = fmul(t, u[0]);
            ty = fmul(t, u[1]);
            tz = fmul(t, u[2]);
            txy = fmul(tx, u[1]);
            txz = fmul(tx, u[2]);
            tyz = fmul(ty, u[2]);
            m[0] = fmul(tx, u[0]) + c;
            m[1] = txy - fmul(s, u[2]);
            m[2] = txz + fmul(s, u[1]);
            m[3] = txy + fmul(s, u[2]);
            m[4] = fmul(ty, u[1]) + c;
            m[5] = tyz - fmul(s, u[0]);
            m[6] = txz - fmul(s, u[1]);
            m[7] = tyz + fmul(s, u[0]);
            m[8] = fmul(tz, u[2]) + c;
         end
      end
      for (int i = 0; i < 9; i++) res.m[i] = round_element(m[i]);
   endtask

   // one request: idle gap, drive at falling edge, hold until accepted
   task automatic send_request(input logic op, input logic signed [AB-1:0] ax, ay, az,
                               spin, input logic signed [EB-1:0] vx, vy, vz,
                               input bit no_gap = 0);
      matrix_type res;
      int gap;
      gap = no_gap ? 0 : int'($urandom_range(0, 5));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_angle_x <= ax;
      req_angle_y <= ay;
      req_angle_z <= az;
      req_spin_angle <= spin;
      req_axis_x <= vx;
      req_axis_y <= vy;
      req_axis_z <= vz;
      build_matrix(op, ax, ay, az, spin, vx, vy, vz, res);
      do @(posedge clock); while (req_stall);
      expected_matrices.push_back(res);
      @(negedge clock);
   endtask

   task automatic idle_input();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_euler_directed();
      logic signed [AB-1:0] ext[6] = '{16'sh7FFF, 16'sh8000, 16'sh0000,
                                       16'sh3244, 16'shCDBC, 16'sh1922};
      foreach (ext[i]) begin
         send_request(OP_EULER, ext[i], '0, '0, rnd_angle(), rnd_axis(), rnd_axis(),
                      rnd_axis());
         send_request(OP_EULER, '0, ext[i], '0, rnd_angle(), rnd_axis(), rnd_axis(),
                      rnd_axis());
         send_request(OP_EULER, '0, '0, ext[i], rnd_angle(), rnd_axis(), rnd_axis(),
                      rnd_axis());
      end
      send_request(OP_EULER, 16'sh7FFF, 16'sh8000, 16'sh7FFF, '0, '0, '0, '0);
      idle_input();
   endtask

   task automatic test_axis_directed();
      send_request(OP_AXIS, rnd_angle(), rnd_angle(), rnd_angle(), 16'sh1922, '0, '0, '0);
      send_request(OP_AXIS, '0, '0, '0, 16'sh7FFF, 16'sh7FFF, '0, '0);
      send_request(OP_AXIS, '0, '0, '0, 16'sh8000, '0, 16'sh8000, '0);
      send_request(OP_AXIS, '0, '0, '0, 16'sh3244, '0, '0, 16'sd1);
      send_request(OP_AXIS, '0, '0, '0, 16'shCDBC, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_request(OP_AXIS, '0, '0, '0, 16'sh0C91, 16'sh8000, 16'sh8000, 16'sh8000);
      send_request(OP_AXIS, '0, '0, '0, '0, -16'sd1, 16'sd1, -16'sd1);
      idle_input();
   endtask

   task automatic test_random_mix();
      bit burst;
      for (int n = 0; n < 1000; n++) begin
         burst = (n / 100) % 3 == 2;
         if ($urandom_range(0, 3) == 0)
            send_request(rnd_op(), rnd_angle(), rnd_angle(), rnd_angle(), rnd_angle(),
                         small_axis(), small_axis(), small_axis(), burst);
         else
            send_request(rnd_op(), rnd_angle(), rnd_angle(), rnd_angle(), rnd_angle(),
                         rnd_axis(), rnd_axis(), rnd_axis(), burst);
      end
      idle_input();
   endtask

   // response side: per response, stall for a drawn number of cycles
   always @(negedge clock) begin
      if (!reset && rsp_valid) begin
         if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
            rsp_wait = ((cycles / 2000) % 3 == 1) ? 0 : int'($urandom_range(0, 5));
         end
      end
   end

   always @(posedge clock) begin
      matrix_type e;
      logic signed [EB-1:0] got[9];
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                 rsp_m20, rsp_m21, rsp_m22};
         if (expected_matrices.size() == 0) begin
            $error("response with no request pending");
            failures++;
         end else begin
            e = expected_matrices.pop_front();
            for (int i = 0; i < 9; i++)
               if (got[i] !== e.m[i]) begin
                  $error("m%0d%0d expected %0d got %0d", i / 3, i % 3, e.m[i], got[i]);
                  failures++;
               end
            if (rsp_zero_axis !== e.zero_axis) begin
               $error("zero_axis expected %0b got %0b", e.zero_axis, rsp_zero_axis);
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_euler_directed();
      test_axis_directed();
      test_random_mix();
      while (expected_matrices.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (failures == 0 && expected_matrices.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
